### design/bmnd_pkg.sv
package bmnd_pkg;

  localparam int MAX_NODES  = 1024;
  localparam int MAX_BLOCKS = 64;

  localparam int OP_W       = 2;
  localparam int IDX_W      = 10;
  localparam int COORD_W    = 32;
  localparam int RAD_W      = 31;
  localparam int NCFG_W     = 11;
  localparam int BCFG_W     = 7;
  localparam int BNUM_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int NODE_AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int NCNT_W  = $clog2(MAX_NODES + 1);
  localparam int BLK_AW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int BCNT_W  = $clog2(MAX_BLOCKS + 1);

  localparam int NCMP_W = (NCFG_W > NCNT_W) ? NCFG_W : NCNT_W;
  localparam int BCMP_W = (BCFG_W > BCNT_W) ? BCFG_W : BCNT_W;
  localparam int IDXN_W = (IDX_W > NCNT_W) ? IDX_W + 1 : NCNT_W + 1;
  localparam int IDXB_W = (IDX_W > BCNT_W) ? IDX_W : BCNT_W;

  localparam int SQ_W  = 2 * COORD_W;
  localparam int TOT_W = SQ_W + 2;
  localparam int R2_W  = 2 * RAD_W;

  localparam logic [OP_W-1:0] OP_LOAD_NODE  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_BLOCK = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY      = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd2;

  localparam logic [RAD_W-1:0] RADIUS_RESET = 31'd6553600;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NODE,
    ST_DRAIN,
    ST_BLK_RD,
    ST_BLK_PRE,
    ST_BLK_EVAL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_node;
    logic load_block;
    logic q_start;
    logic node_issue;
    logic blk_rd;
    logic blk_pre;
    logic blk_eval;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic nn_zero;
    logic nb_zero;
    logic node_last;
    logic pipe_busy;
    logic blk_last;
    logic eval_stall;
    logic out_free;
  } stat_t;

endpackage

### design/bmnd_if.sv
interface bmnd_in_if;
  import bmnd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           opcode;
  logic [IDX_W-1:0]          entry_index;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;
  logic [IDX_W-1:0]          first_node;
  logic [IDX_W-1:0]          last_node;

  modport source (output valid, opcode, entry_index, coord_x, coord_y, coord_z,
                  first_node, last_node, input ready);
  modport sink (input valid, opcode, entry_index, coord_x, coord_y, coord_z,
                first_node, last_node, output ready);
endinterface

interface bmnd_out_if;
  import bmnd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BNUM_W-1:0] block_number;
  logic              found;
  logic              last;

  modport source (output valid, block_number, found, last, input ready);
  modport sink (input valid, block_number, found, last, output ready);
endinterface

interface bmnd_cfg_if;
  import bmnd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/block_membership_by_node_distance_unit.sv
// Load items (node or block entry) are taken in idle; the unit stays ready after each load.
// A query issues one node per cycle through a five-stage squared-distance pipeline,
// then for each block does the table read, the near-count lookup and the check, in that
// order. Results may stall the block scan.
// Synchronous active-low reset clears control and sets radius to 100.0; node and block
// tables are undefined until loaded, and no clearing pass is needed.
module block_membership_by_node_distance_unit (
  input logic        clk,
  input logic        rst_n,
  bmnd_in_if.sink    in_ch,
  bmnd_out_if.source out_ch,
  bmnd_cfg_if.sink   cfg_ch
);
  import bmnd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ch.ready = 1'b1;

  bmnd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bmnd_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_entry_index   (in_ch.entry_index),
    .in_coord_x       (in_ch.coord_x),
    .in_coord_y       (in_ch.coord_y),
    .in_coord_z       (in_ch.coord_z),
    .in_first_node    (in_ch.first_node),
    .in_last_node     (in_ch.last_node),
    .cfg_valid        (cfg_ch.valid),
    .cfg_index        (cfg_ch.index),
    .cfg_data         (cfg_ch.data),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_block_number (out_ch.block_number),
    .out_found        (out_ch.found),
    .out_last         (out_ch.last)
  );

endmodule

### design/bmnd_ctrl.sv
module bmnd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [bmnd_pkg::OP_W-1:0] in_opcode,
  output logic                  in_ready,
  input  bmnd_pkg::stat_t       stat,
  output bmnd_pkg::cmd_t        cmd
);
  import bmnd_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_opcode)
            OP_LOAD_NODE: begin
              cmd.load_node = 1'b1;
            end
            OP_LOAD_BLOCK: begin
              cmd.load_block = 1'b1;
            end
            OP_QUERY: begin
              cmd.q_start = 1'b1;
              state_nxt   = stat.nn_zero ? ST_DRAIN : ST_NODE;
            end
            default: ;
          endcase
        end
      end
      ST_NODE: begin
        cmd.node_issue = 1'b1;
        if (stat.node_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = stat.nb_zero ? ST_FINISH : ST_BLK_RD;
        end
      end
      ST_BLK_RD: begin
        cmd.blk_rd = 1'b1;
        state_nxt  = ST_BLK_PRE;
      end
      ST_BLK_PRE: begin
        cmd.blk_pre = 1'b1;
        state_nxt   = ST_BLK_EVAL;
      end
      ST_BLK_EVAL: begin
        if (!stat.eval_stall) begin
          cmd.blk_eval = 1'b1;
          state_nxt    = stat.blk_last ? ST_FINISH : ST_BLK_RD;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### design/bmnd_datapath.sv
module bmnd_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bmnd_pkg::cmd_t                    cmd,
  output bmnd_pkg::stat_t                   stat,
  input  logic [bmnd_pkg::IDX_W-1:0]        in_entry_index,
  input  logic signed [bmnd_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [bmnd_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [bmnd_pkg::COORD_W-1:0] in_coord_z,
  input  logic [bmnd_pkg::IDX_W-1:0]        in_first_node,
  input  logic [bmnd_pkg::IDX_W-1:0]        in_last_node,
  input  logic                              cfg_valid,
  input  logic [bmnd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bmnd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bmnd_pkg::BNUM_W-1:0]       out_block_number,
  output logic                              out_found,
  output logic                              out_last
);
  import bmnd_pkg::*;

  function automatic logic [COORD_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                  input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    logic [COORD_W:0]        m;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    m = d[COORD_W] ? (~d + 1'b1) : d;
    return m[COORD_W-1:0];
  endfunction

  // configuration registers
  logic [RAD_W-1:0]  radius_r;
  logic [NCFG_W-1:0] node_count_r;
  logic [BCFG_W-1:0] block_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r      <= RADIUS_RESET;
      node_count_r  <= '0;
      block_count_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RADIUS:      radius_r      <= cfg_data[RAD_W-1:0];
        REG_NODE_COUNT:  node_count_r  <= cfg_data[NCFG_W-1:0];
        REG_BLOCK_COUNT: block_count_r <= cfg_data[BCFG_W-1:0];
        default: ;
      endcase
    end
  end

  logic [NCMP_W-1:0] ncfg_ext;
  logic [BCMP_W-1:0] bcfg_ext;
  logic [NCNT_W-1:0] nn;
  logic [BCNT_W-1:0] nb;

  assign ncfg_ext = NCMP_W'(node_count_r);
  assign bcfg_ext = BCMP_W'(block_count_r);
  assign nn = (ncfg_ext > NCMP_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES) : NCNT_W'(ncfg_ext);
  assign nb = (bcfg_ext > BCMP_W'(MAX_BLOCKS)) ? BCNT_W'(MAX_BLOCKS) : BCNT_W'(bcfg_ext);

  // query registers
  logic signed [COORD_W-1:0] qx_r;
  logic signed [COORD_W-1:0] qy_r;
  logic signed [COORD_W-1:0] qz_r;
  logic [R2_W-1:0]           r2_r;

  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      qx_r <= in_coord_x;
      qy_r <= in_coord_y;
      qz_r <= in_coord_z;
      r2_r <= R2_W'(radius_r) * R2_W'(radius_r);
    end
  end

  // node table
  logic [COORD_W-1:0] node_x_mem [MAX_NODES];
  logic [COORD_W-1:0] node_y_mem [MAX_NODES];
  logic [COORD_W-1:0] node_z_mem [MAX_NODES];
  logic signed [COORD_W-1:0] rd_x_r;
  logic signed [COORD_W-1:0] rd_y_r;
  logic signed [COORD_W-1:0] rd_z_r;
  logic [NCNT_W-1:0]  node_idx_r;
  logic               node_we;

  assign node_we = cmd.load_node && (IDXN_W'(in_entry_index) < IDXN_W'(MAX_NODES));

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_x_mem[NODE_AW'(in_entry_index)] <= in_coord_x;
      node_y_mem[NODE_AW'(in_entry_index)] <= in_coord_y;
      node_z_mem[NODE_AW'(in_entry_index)] <= in_coord_z;
    end
    if (cmd.node_issue) begin
      rd_x_r <= node_x_mem[NODE_AW'(node_idx_r)];
      rd_y_r <= node_y_mem[NODE_AW'(node_idx_r)];
      rd_z_r <= node_z_mem[NODE_AW'(node_idx_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_idx_r <= '0;
    end else if (cmd.q_start) begin
      node_idx_r <= '0;
    end else if (cmd.node_issue) begin
      node_idx_r <= node_idx_r + 1'b1;
    end
  end

  // distance pipeline
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [NODE_AW-1:0] idx1_r, idx2_r, idx3_r, idx4_r, idx5_r;
  logic [COORD_W-1:0] dx_r, dy_r, dz_r;
  logic [SQ_W-1:0]    sqx_r, sqy_r, sqz_r;
  logic [SQ_W:0]      sxy_r;
  logic [SQ_W-1:0]    sz_r;
  logic [TOT_W-1:0]   tot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= cmd.node_issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= NODE_AW'(node_idx_r);
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
    idx4_r <= idx3_r;
    idx5_r <= idx4_r;
    dx_r   <= abs_diff(qx_r, rd_x_r);
    dy_r   <= abs_diff(qy_r, rd_y_r);
    dz_r   <= abs_diff(qz_r, rd_z_r);
    sqx_r  <= SQ_W'(dx_r) * SQ_W'(dx_r);
    sqy_r  <= SQ_W'(dy_r) * SQ_W'(dy_r);
    sqz_r  <= SQ_W'(dz_r) * SQ_W'(dz_r);
    sxy_r  <= (SQ_W + 1)'(sqx_r) + (SQ_W + 1)'(sqy_r);
    sz_r   <= sqz_r;
    tot_r  <= TOT_W'(sxy_r) + TOT_W'(sz_r);
  end

  // running count of near nodes: pre_mem[i] = near nodes below index i
  logic [NCNT_W-1:0] pre_mem [MAX_NODES + 1];
  logic [NCNT_W-1:0] cnt_r;
  logic              near;
  logic              pre_we;
  logic [NCNT_W-1:0] pre_waddr;
  logic [NCNT_W-1:0] pre_wdata;

  assign near      = (tot_r <= TOT_W'(r2_r));
  assign pre_we    = cmd.q_start || v5_r;
  assign pre_waddr = cmd.q_start ? '0 : (NCNT_W'(idx5_r) + 1'b1);
  assign pre_wdata = cmd.q_start ? '0 : (cnt_r + NCNT_W'(near));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.q_start) begin
      cnt_r <= '0;
    end else if (v5_r) begin
      cnt_r <= pre_wdata;
    end
  end

  // block table
  logic [IDX_W-1:0]  blk_first_mem [MAX_BLOCKS];
  logic [IDX_W-1:0]  blk_last_mem [MAX_BLOCKS];
  logic [IDX_W-1:0]  bf_r;
  logic [IDX_W-1:0]  bl_r;
  logic [BCNT_W-1:0] blk_idx_r;
  logic              block_we;

  assign block_we = cmd.load_block && (IDXB_W'(in_entry_index) < IDXB_W'(MAX_BLOCKS));

  always_ff @(posedge clk) begin
    if (block_we) begin
      blk_first_mem[BLK_AW'(in_entry_index)] <= in_first_node;
      blk_last_mem[BLK_AW'(in_entry_index)]  <= in_last_node;
    end
    if (cmd.blk_rd) begin
      bf_r <= blk_first_mem[BLK_AW'(blk_idx_r)];
      bl_r <= blk_last_mem[BLK_AW'(blk_idx_r)];
    end
  end

  // range check and count lookup
  logic [IDXN_W-1:0] first_c;
  logic [IDXN_W-1:0] last_c;
  logic [IDXN_W-1:0] nn_c;
  logic [IDXN_W-1:0] end_c;
  logic              range_ok;
  logic [NCNT_W-1:0] hi_addr;
  logic [NCNT_W-1:0] lo_addr;
  logic [NCNT_W-1:0] pre_hi_r;
  logic [NCNT_W-1:0] pre_lo_r;
  logic              ok_r;

  assign first_c  = IDXN_W'(bf_r);
  assign last_c   = IDXN_W'(bl_r);
  assign nn_c     = IDXN_W'(nn);
  assign range_ok = (first_c <= last_c) && (first_c < nn_c);
  assign end_c    = (last_c >= nn_c) ? nn_c : (last_c + 1'b1);
  assign hi_addr  = range_ok ? NCNT_W'(end_c) : '0;
  assign lo_addr  = range_ok ? NCNT_W'(first_c) : '0;

  always_ff @(posedge clk) begin
    if (pre_we) begin
      pre_mem[pre_waddr] <= pre_wdata;
    end
    if (cmd.blk_pre) begin
      pre_hi_r <= pre_mem[hi_addr];
      pre_lo_r <= pre_mem[lo_addr];
      ok_r     <= range_ok;
    end
  end

  // block scan and result ordering
  logic              hit;
  logic              pend_valid_r;
  logic [BNUM_W-1:0] pend_num_r;
  logic              out_valid_r;
  logic [BNUM_W-1:0] out_num_r;
  logic              out_found_r;
  logic              out_last_r;
  logic              out_free;
  logic              out_load;

  assign hit      = ok_r && (pre_hi_r != pre_lo_r);
  assign out_free = !out_valid_r || out_ready;
  assign out_load = (cmd.blk_eval && hit && pend_valid_r) || cmd.finish;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_idx_r    <= '0;
      pend_valid_r <= 1'b0;
    end else if (cmd.q_start) begin
      blk_idx_r    <= '0;
      pend_valid_r <= 1'b0;
    end else if (cmd.blk_eval) begin
      blk_idx_r <= blk_idx_r + 1'b1;
      if (hit) begin
        pend_valid_r <= 1'b1;
      end
    end else if (cmd.finish) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.blk_eval && hit) begin
      pend_num_r <= BNUM_W'(blk_idx_r) + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_num_r   <= pend_valid_r ? pend_num_r : '0;
      out_found_r <= pend_valid_r;
      out_last_r  <= cmd.finish;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_block_number = out_num_r;
  assign out_found        = out_found_r;
  assign out_last         = out_last_r;

  assign stat.nn_zero    = (nn == '0);
  assign stat.nb_zero    = (nb == '0);
  assign stat.node_last  = ((node_idx_r + 1'b1) == nn);
  assign stat.pipe_busy  = v1_r || v2_r || v3_r || v4_r || v5_r;
  assign stat.blk_last   = ((blk_idx_r + 1'b1) == nb);
  assign stat.eval_stall = hit && pend_valid_r && !out_free;
  assign stat.out_free   = out_free;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import bmnd_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int ONE            = 65536;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TIMEOUT_CYCLES = 400000;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [IDX_W-1:0]   entry_index;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [IDX_W-1:0]   first_node;
    logic [IDX_W-1:0]   last_node;
  } bmnd_item_t;

  typedef struct packed {
    logic [BNUM_W-1:0] block_number;
    logic              found;
    logic              last;
  } block_hit_t;

  logic clk;
  logic rst_n;

  bmnd_in_if  in_if();
  bmnd_out_if out_if();
  bmnd_cfg_if cfg_if();

  block_membership_by_node_distance_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  bmnd_item_t pending_items[$];
  block_hit_t expected_hits[$];

  logic [RAD_W-1:0]   radius_m;
  logic [NCFG_W-1:0]  node_cnt_m;
  logic [BCFG_W-1:0]  block_cnt_m;
  logic [COORD_W-1:0] pos_x[MAX_NODES];
  logic [COORD_W-1:0] pos_y[MAX_NODES];
  logic [COORD_W-1:0] pos_z[MAX_NODES];
  logic [IDX_W-1:0]   blk_lo[MAX_BLOCKS];
  logic [IDX_W-1:0]   blk_hi[MAX_BLOCKS];
  bit                 near_node[MAX_NODES];

  int errors;
  int cycles;
  int in_gap;
  int out_stall;
  bit quiet;
  bit in_fire;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------- predictor ----------------

  function automatic logic [67:0] axis_sq(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
    logic signed [33:0] d;
    logic [33:0]        m;
    logic [67:0]        w;
    d = $signed({{2{a[31]}}, a}) - $signed({{2{b[31]}}, b});
    m = d[33] ? -d : d;
    w = m;
    return w * w;
  endfunction

  function automatic void predict_query(logic [COORD_W-1:0] qx, logic [COORD_W-1:0] qy,
                                        logic [COORD_W-1:0] qz);
    int          nn;
    int          nb;
    int          hits;
    bit          seen;
    logic [69:0] dist2;
    logic [69:0] lim;
    block_hit_t  h;
    nn = (node_cnt_m > MAX_NODES) ? MAX_NODES : node_cnt_m;
    nb = (block_cnt_m > MAX_BLOCKS) ? MAX_BLOCKS : block_cnt_m;
    lim = radius_m;
    lim = lim * lim;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (i < nn) begin
        dist2 = axis_sq(qx, pos_x[i]) + axis_sq(qy, pos_y[i]) + axis_sq(qz, pos_z[i]);
        near_node[i] = (dist2 <= lim);
      end else begin
        near_node[i] = 1'b0;
      end
    end
    hits = 0;
    for (int b = 0; b < nb; b++) begin
      seen = 1'b0;
      for (int j = blk_lo[b]; j <= blk_hi[b] && j < nn; j++) begin
        if (near_node[j]) seen = 1'b1;
      end
      if (seen) begin
        h.block_number = BNUM_W'(b + 1);
        h.found = 1'b1;
        h.last = 1'b0;
        expected_hits = {expected_hits, h};
        hits++;
      end
    end
    if (hits == 0) begin
      h.block_number = '0;
      h.found = 1'b0;
      h.last = 1'b1;
      expected_hits = {expected_hits, h};
    end else begin
      expected_hits[expected_hits.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void predict_item(bmnd_item_t it);
    case (it.opcode)
      OP_LOAD_NODE: begin
        pos_x[it.entry_index] = it.x;
        pos_y[it.entry_index] = it.y;
        pos_z[it.entry_index] = it.z;
      end
      OP_LOAD_BLOCK: begin
        if (it.entry_index < MAX_BLOCKS) begin
          blk_lo[it.entry_index] = it.first_node;
          blk_hi[it.entry_index] = it.last_node;
        end
      end
      OP_QUERY: predict_query(it.x, it.y, it.z);
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // ---------------- sampling and checking ----------------

  always @(posedge clk) begin
    bmnd_item_t acc;
    block_hit_t want;
    cycles++;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("[block_membership_by_node_distance_unit] ERROR");
      $finish;
    end else if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_RADIUS:      radius_m = cfg_if.data[RAD_W-1:0];
          REG_NODE_COUNT:  node_cnt_m = cfg_if.data[NCFG_W-1:0];
          REG_BLOCK_COUNT: block_cnt_m = cfg_if.data[BCFG_W-1:0];
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_hits.size() == 0) begin
          errors++;
          $display({"%0t: unexpected transfer: expected none, ",
                    "actual block_number=%0d found=%0b last=%0b"},
                   $time, out_if.block_number, out_if.found, out_if.last);
        end else begin
          want = expected_hits.pop_front();
          check_field("block_number", want.block_number, out_if.block_number);
          check_field("found", want.found, out_if.found);
          check_field("last", want.last, out_if.last);
        end
      end
      if (in_if.valid && in_if.ready) begin
        acc.opcode = in_if.opcode;
        acc.entry_index = in_if.entry_index;
        acc.x = in_if.coord_x;
        acc.y = in_if.coord_y;
        acc.z = in_if.coord_z;
        acc.first_node = in_if.first_node;
        acc.last_node = in_if.last_node;
        predict_item(acc);
      end
      in_fire <= in_if.valid && in_if.ready;
    end
  end

  // ---------------- driving ----------------

  always @(negedge clk) begin
    bmnd_item_t it;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      out_if.ready <= 1'b0;
      in_gap = 0;
      out_stall = 0;
    end else begin
      if (in_fire || !in_if.valid) begin
        if (in_gap > 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          it = pending_items.pop_front();
          in_if.opcode <= it.opcode;
          in_if.entry_index <= it.entry_index;
          in_if.coord_x <= it.x;
          in_if.coord_y <= it.y;
          in_if.coord_z <= it.z;
          in_if.first_node <= it.first_node;
          in_if.last_node <= it.last_node;
          in_if.valid <= 1'b1;
          if (!quiet && $urandom_range(0, 4) == 0) in_gap = $urandom_range(1, 3);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      if (quiet) begin
        out_if.ready <= 1'b1;
      end else if (out_stall > 0) begin
        out_stall--;
        out_if.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        out_stall = $urandom_range(0, 2);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------- stimulus ----------------

  task automatic push_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input int x, input int y, input int z,
                           input logic [IDX_W-1:0] f, input logic [IDX_W-1:0] l);
    bmnd_item_t it;
    it.opcode = op;
    it.entry_index = idx;
    it.x = x;
    it.y = y;
    it.z = z;
    it.first_node = f;
    it.last_node = l;
    pending_items = {pending_items, it};
  endtask

  task automatic push_node(input int idx, input int x, input int y, input int z);
    push_item(OP_LOAD_NODE, IDX_W'(idx), x, y, z, IDX_W'($urandom), IDX_W'($urandom));
  endtask

  task automatic push_block(input int idx, input int f, input int l);
    push_item(OP_LOAD_BLOCK, IDX_W'(idx), $urandom, $urandom, $urandom, IDX_W'(f), IDX_W'(l));
  endtask

  task automatic push_query(input int x, input int y, input int z);
    push_item(OP_QUERY, IDX_W'($urandom), x, y, z, IDX_W'($urandom), IDX_W'($urandom));
  endtask

  task automatic push_random_block(input int b, input int n_nodes);
    int f;
    f = $urandom_range(0, n_nodes + 1);
    case ($urandom_range(0, 7))
      0: push_block(b, $urandom, $urandom);
      1: push_block(b, f + 3, f);
      default: push_block(b, f, f + $urandom_range(0, 6));
    endcase
  endtask

  function automatic int jitter(int c, int s);
    return c + int'($urandom_range(0, 2 * s)) - s;
  endfunction

  // upper data bits beyond the register width are don't-care
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val, input int w);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= ($urandom << w) | val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_idle(input int settle);
    while (pending_items.size() != 0 || in_if.valid || expected_hits.size() != 0)
      @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic random_phase(input int n_nodes, input int n_items);
    int cx, cy, cz, rad, spread, nb, r;
    rad = $urandom_range(ONE, 200 * ONE);
    spread = 2 * rad;
    cx = int'($urandom_range(0, 1 << 25)) - (1 << 24);
    cy = int'($urandom_range(0, 1 << 25)) - (1 << 24);
    cz = int'($urandom_range(0, 1 << 25)) - (1 << 24);
    nb = $urandom_range(1, 6);
    for (int i = 0; i < n_nodes; i++)
      push_node(i, jitter(cx, spread), jitter(cy, spread), jitter(cz, spread));
    for (int b = 0; b < nb; b++) push_random_block(b, n_nodes);
    wait_idle(SETTLE_CYCLES);
    write_reg(REG_RADIUS, rad, RAD_W);
    write_reg(REG_NODE_COUNT, n_nodes, NCFG_W);
    write_reg(REG_BLOCK_COUNT, nb, BCFG_W);
    for (int k = 0; k < n_items; k++) begin
      if (k == n_items / 2) wait_idle(0);
      r = $urandom_range(0, 99);
      if (r < 65) begin
        push_query(jitter(cx, spread), jitter(cy, spread), jitter(cz, spread));
      end else if (r < 70) begin
        push_query($urandom, $urandom, $urandom);
      end else if (r < 78) begin
        push_node($urandom_range(0, n_nodes - 1), jitter(cx, spread), jitter(cy, spread),
                  jitter(cz, spread));
      end else if (r < 85) begin
        push_random_block($urandom_range(0, nb - 1), n_nodes);
      end else if (r < 91) begin
        push_node($urandom_range(0, MAX_NODES - 1), $urandom, $urandom, $urandom);
      end else if (r < 96) begin
        push_block($urandom_range(MAX_BLOCKS, 1023), $urandom, $urandom);
      end else begin
        push_item(OP_UNUSED, IDX_W'($urandom), $urandom, $urandom, $urandom,
                  IDX_W'($urandom), IDX_W'($urandom));
      end
    end
    wait_idle(SETTLE_CYCLES);
  endtask

  initial begin
    rst_n = 1'b0;
    errors = 0;
    cycles = 0;
    quiet = 1'b0;
    in_fire = 1'b0;
    in_gap = 0;
    out_stall = 0;
    radius_m = RADIUS_RESET;
    node_cnt_m = '0;
    block_cnt_m = '0;
    in_if.valid = 1'b0;
    in_if.opcode = OP_LOAD_NODE;
    in_if.entry_index = '0;
    in_if.coord_x = '0;
    in_if.coord_y = '0;
    in_if.coord_z = '0;
    in_if.first_node = '0;
    in_if.last_node = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_RADIUS;
    cfg_if.data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // counts are zero after reset: nothing can be found
    push_query(0, 0, 0);
    push_item(OP_UNUSED, IDX_W'($urandom), $urandom, $urandom, $urandom,
              IDX_W'($urandom), IDX_W'($urandom));
    push_block(1023, 0, 5);
    push_node(0, 0, 0, 0);
    push_node(1, 100 * ONE, 0, 0);
    push_node(2, 0, 100 * ONE + 1, 0);
    push_node(3, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    push_node(4, 32'h80000000, 32'h80000000, 32'h80000000);
    push_node(5, -3 * ONE, 4 * ONE, 0);
    push_block(0, 0, 0);
    push_block(1, 1, 1);
    push_block(2, 2, 2);
    push_block(3, 3, 4);
    push_block(4, 5, 2);
    push_block(5, 4, 1023);
    push_block(6, 2, 2);
    wait_idle(SETTLE_CYCLES);
    write_reg(REG_RADIUS, RADIUS_RESET, RAD_W);
    write_reg(REG_NODE_COUNT, 6, NCFG_W);
    write_reg(REG_BLOCK_COUNT, 7, BCFG_W);
    push_query(0, 0, 0);
    push_query(32'h80000000, 32'h80000000, 32'h80000000);
    push_query(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    push_query(0, -200 * ONE, 0);
    wait_idle(SETTLE_CYCLES);
    write_reg(REG_RADIUS, 0, RAD_W);
    push_query(100 * ONE, 0, 0);
    wait_idle(SETTLE_CYCLES);
    write_reg(REG_RADIUS, 32'h7FFFFFFF, RAD_W);
    push_query(0, 0, 0);
    wait_idle(SETTLE_CYCLES);
    write_reg(REG_NODE_COUNT, 0, NCFG_W);
    push_query(0, 0, 0);
    wait_idle(SETTLE_CYCLES);
    write_reg(REG_NODE_COUNT, 6, NCFG_W);
    write_reg(REG_BLOCK_COUNT, 0, BCFG_W);
    push_query(0, 0, 0);
    wait_idle(SETTLE_CYCLES);

    random_phase(1, 8);
    random_phase(12, 14);
    random_phase(6, 12);
    quiet = 1'b1;
    random_phase(8, 10);

    wait_idle(64);
    if (errors == 0) begin
      $display("[block_membership_by_node_distance_unit] OK");
    end else begin
      $display("[block_membership_by_node_distance_unit] ERROR");
    end
    $finish;
  end

endmodule
